### rtl/slc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slc_pkg
// shared constants, codes and helpers of the set-associative lru cache model
// ----------------------------------------------------------------------------
package slc_pkg;

  localparam int MAX_SET_BITS_DEF = 8;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 64;

  localparam int STAMP_W   = 64;
  localparam int CNT_W     = 32;
  localparam int KIND_W    = 2;
  localparam int OUTCOME_W = 2;
  localparam int OP_W      = 2;

  // configuration port
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 6;
  localparam int SET_BITS_W       = 4;
  localparam int BLOCK_BITS_W     = 6;
  localparam int WAYS_IN_USE_W    = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_FETCH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LDST   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // classified operations
  localparam logic [OP_W-1:0] OP_NONE   = 2'd0;
  localparam logic [OP_W-1:0] OP_SINGLE = 2'd1;
  localparam logic [OP_W-1:0] OP_DOUBLE = 2'd2;

  // outcomes
  localparam logic [OUTCOME_W-1:0] OUT_NONE  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  // saturating add of 0, 1 or 2
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [1:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, v} + {{(CNT_W - 1){1'b0}}, n};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/slc_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slc channel interfaces
// access request channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface slc_req_if #(
  parameter int ADDR_WIDTH = slc_pkg::ADDR_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [slc_pkg::KIND_W-1:0]  kind;
  logic [ADDR_WIDTH-1:0]       access_address;

  modport source (output valid, output kind, output access_address, input ready);
  modport sink   (input valid, input kind, input access_address, output ready);
endinterface

interface slc_rsp_if ();
  logic                           valid;
  logic                           ready;
  logic [slc_pkg::OUTCOME_W-1:0]  first_outcome;
  logic                           second_hit;
  logic [slc_pkg::CNT_W-1:0]      total_hits;
  logic [slc_pkg::CNT_W-1:0]      total_misses;
  logic [slc_pkg::CNT_W-1:0]      total_evictions;

  modport source (output valid, output first_outcome, output second_hit,
                  output total_hits, output total_misses, output total_evictions,
                  input ready);
  modport sink   (input valid, input first_outcome, input second_hit,
                  input total_hits, input total_misses, input total_evictions,
                  output ready);
endinterface
`default_nettype wire

### rtl/slc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slc_queue
// small fifo between the classify front and the lookup back
// ----------------------------------------------------------------------------
module slc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = slc_pkg::QUEUE_DEPTH
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  wire [WIDTH-1:0]  push_data,
  input  wire              pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/slc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slc_front
// accepts access requests, classifies the kind and splits the address
// ----------------------------------------------------------------------------
module slc_front #(
  parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
  parameter int ADDR_WIDTH   = slc_pkg::ADDR_WIDTH_DEF,
  parameter int IDX_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  parameter int ENTRY_W      = slc_pkg::OP_W + IDX_W + ADDR_WIDTH
) (
  input  wire                                 clk,
  input  wire                                 rst,
  slc_req_if.sink                             req,
  input  wire [slc_pkg::SET_BITS_W-1:0]       set_bits,
  input  wire [slc_pkg::BLOCK_BITS_W-1:0]     block_bits,
  input  wire                                 clearing,
  input  wire                                 q_full,
  output logic                                q_push,
  output logic [ENTRY_W-1:0]                  q_data
);
  logic [slc_pkg::SET_BITS_W-1:0] sb;
  logic [6:0]                     split;
  logic [ADDR_WIDTH-1:0]          tag;
  logic [ADDR_WIDTH-1:0]          shifted;
  logic [IDX_W-1:0]               mask;
  logic [IDX_W-1:0]               idx;
  logic [slc_pkg::OP_W-1:0]       op;
  logic                           hold;

  // no state of its own beyond a reset guard on ready
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b1;
    end else begin
      hold <= 1'b0;
    end
  end

  assign req.ready = !q_full && !clearing && !hold;
  assign q_push    = req.valid && req.ready;

  always_comb begin
    sb = (set_bits > slc_pkg::SET_BITS_W'(MAX_SET_BITS))
         ? slc_pkg::SET_BITS_W'(MAX_SET_BITS) : set_bits;
    split = {3'b000, sb} + {1'b0, block_bits};
    tag   = (split >= 7'(ADDR_WIDTH)) ? '0 : (req.access_address >> split);
    shifted = req.access_address >> block_bits;
    for (int i = 0; i < IDX_W; i++) begin
      mask[i] = (5'(i) < {1'b0, sb});
    end
    idx = shifted[IDX_W-1:0] & mask;
  end

  always_comb begin
    unique case (req.kind) inside
      slc_pkg::KIND_LDST:   op = slc_pkg::OP_SINGLE;
      slc_pkg::KIND_MODIFY: op = slc_pkg::OP_DOUBLE;
      default:              op = slc_pkg::OP_NONE;
    endcase
  end

  assign q_data = {op, idx, tag};
endmodule
`default_nettype wire

### rtl/slc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slc_back
// set lookup, victim choice, line update, totals and result register
// ----------------------------------------------------------------------------
module slc_back #(
  parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = slc_pkg::ADDR_WIDTH_DEF,
  parameter int IDX_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  parameter int ENTRY_W      = slc_pkg::OP_W + IDX_W + ADDR_WIDTH
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire [slc_pkg::WAYS_IN_USE_W-1:0]    ways_in_use,
  input  wire                                 q_empty,
  input  wire [ENTRY_W-1:0]                   q_data,
  output logic                                q_pop,
  output logic                                clearing,
  slc_rsp_if.source                           rsp
);
  localparam int NSETS     = 1 << MAX_SET_BITS;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
  localparam int SWEEP_W   = IDX_W + 1;
  localparam int STAMP_W   = slc_pkg::STAMP_W;
  localparam int CNT_W     = slc_pkg::CNT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_LRU   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  // set memory, one row per set
  logic [MAX_WAYS-1:0]                  mem_valid [NSETS];
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  mem_tag   [NSETS];
  logic [MAX_WAYS-1:0][STAMP_W-1:0]     mem_stamp [NSETS];

  logic [MAX_WAYS-1:0]                  rd_valid;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  rd_tag;
  logic [MAX_WAYS-1:0][STAMP_W-1:0]     rd_stamp;
  logic [MAX_WAYS-1:0]                  wr_valid;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  wr_tag;
  logic [MAX_WAYS-1:0][STAMP_W-1:0]     wr_stamp;
  logic                                 rd_en;
  logic                                 wr_en;
  logic [IDX_W-1:0]                     wr_addr;

  logic [2:0]                    state;
  logic [SWEEP_W-1:0]            sweep;
  logic [slc_pkg::OP_W-1:0]      cur_op;
  logic [IDX_W-1:0]              cur_idx;
  logic [ADDR_WIDTH-1:0]         cur_tag;
  logic [WAY_W-1:0]              way_sel;
  logic [WAY_CNT_W-1:0]          scan;
  logic [slc_pkg::OUTCOME_W-1:0] outcome;
  logic [STAMP_W-1:0]            access_clock;
  logic [CNT_W-1:0]              hit_total;
  logic [CNT_W-1:0]              miss_total;
  logic [CNT_W-1:0]              evict_total;

  logic [4:0]           ways_req;
  logic [4:0]           ways_lim;
  logic [WAY_CNT_W-1:0] way_count;
  logic                 hit_found;
  logic [WAY_W-1:0]     hit_way;
  logic                 free_found;
  logic [WAY_W-1:0]     free_way;
  logic [1:0]           step;
  logic [STAMP_W-1:0]   new_stamp;

  logic                           out_valid;
  logic [slc_pkg::OUTCOME_W-1:0]  out_first;
  logic                           out_second;
  logic [CNT_W-1:0]               out_hits;
  logic [CNT_W-1:0]               out_misses;
  logic [CNT_W-1:0]               out_evicts;

  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign rd_en    = q_pop;

  // way count in use, clamped to the built range
  always_comb begin
    ways_req = {1'b0, ways_in_use};
    if (ways_req == 5'd0) begin
      ways_lim = 5'd1;
    end else if (ways_req > 5'(MAX_WAYS)) begin
      ways_lim = 5'(MAX_WAYS);
    end else begin
      ways_lim = ways_req;
    end
    way_count = WAY_CNT_W'(ways_lim);
  end

  // tag match and first free way over the row just read
  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_CNT_W'(w) < way_count) begin
        if (rd_valid[w] && (rd_tag[w] == cur_tag) && !hit_found) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(w);
        end
        if (!rd_valid[w] && !free_found) begin
          free_found = 1'b1;
          free_way   = WAY_W'(w);
        end
      end
    end
  end

  // a modify ticks the clock twice, the second tick on the same line
  assign step      = (cur_op == slc_pkg::OP_DOUBLE) ? 2'd2 : 2'd1;
  assign new_stamp = access_clock + {{(STAMP_W - 2){1'b0}}, step};

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = cur_idx;
    wr_valid = rd_valid;
    wr_tag   = rd_tag;
    wr_stamp = rd_stamp;
    if (state == S_CLEAR) begin
      wr_en    = 1'b1;
      wr_addr  = sweep[IDX_W-1:0];
      wr_valid = '0;
      wr_stamp = '0;
    end else if (state == S_WRITE) begin
      wr_en             = 1'b1;
      wr_valid[way_sel] = 1'b1;
      wr_tag[way_sel]   = cur_tag;
      wr_stamp[way_sel] = new_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_valid[wr_addr] <= wr_valid;
      mem_tag[wr_addr]   <= wr_tag;
      mem_stamp[wr_addr] <= wr_stamp;
    end
    if (rd_en) begin
      rd_valid <= mem_valid[q_data[ADDR_WIDTH +: IDX_W]];
      rd_tag   <= mem_tag[q_data[ADDR_WIDTH +: IDX_W]];
      rd_stamp <= mem_stamp[q_data[ADDR_WIDTH +: IDX_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_op  <= q_data[ENTRY_W-1 -: slc_pkg::OP_W];
      cur_idx <= q_data[ADDR_WIDTH +: IDX_W];
      cur_tag <= q_data[ADDR_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      sweep        <= '0;
      way_sel      <= '0;
      scan         <= '0;
      outcome      <= slc_pkg::OUT_NONE;
      access_clock <= '0;
      hit_total    <= '0;
      miss_total   <= '0;
      evict_total  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == SWEEP_W'(NSETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            if (q_data[ENTRY_W-1 -: slc_pkg::OP_W] == slc_pkg::OP_NONE) begin
              outcome <= slc_pkg::OUT_NONE;
              state   <= S_RESP;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (hit_found) begin
            way_sel <= hit_way;
            outcome <= slc_pkg::OUT_HIT;
            state   <= S_WRITE;
          end else if (free_found) begin
            way_sel <= free_way;
            outcome <= slc_pkg::OUT_MISS;
            state   <= S_WRITE;
          end else begin
            way_sel <= '0;
            scan    <= WAY_CNT_W'(1);
            outcome <= slc_pkg::OUT_EVICT;
            state   <= S_LRU;
          end
        end
        S_LRU: begin
          // one way a cycle, strict less-than keeps ties on the lower way
          if (scan < way_count) begin
            if (rd_stamp[scan[WAY_W-1:0]] < rd_stamp[way_sel]) begin
              way_sel <= scan[WAY_W-1:0];
            end
            scan <= scan + 1'b1;
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          access_clock <= new_stamp;
          if (outcome == slc_pkg::OUT_HIT) begin
            hit_total <= slc_pkg::sat_add(hit_total, step);
          end else begin
            hit_total  <= slc_pkg::sat_add(hit_total, step - 2'd1);
            miss_total <= slc_pkg::sat_add(miss_total, 2'd1);
            if (outcome == slc_pkg::OUT_EVICT) begin
              evict_total <= slc_pkg::sat_add(evict_total, 2'd1);
            end
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESP) && (!out_valid || rsp.ready)) begin
      out_first   <= outcome;
      out_second  <= (cur_op == slc_pkg::OP_DOUBLE);
      out_hits    <= hit_total;
      out_misses  <= miss_total;
      out_evicts  <= evict_total;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.first_outcome   = out_first;
  assign rsp.second_hit      = out_second;
  assign rsp.total_hits      = out_hits;
  assign rsp.total_misses    = out_misses;
  assign rsp.total_evictions = out_evicts;
endmodule
`default_nettype wire

### rtl/set_assoc_lru_cache_model_top.sv
`default_nettype none
// a hit or a free-way fill goes through the queue and the idle (row read), look, write
// and resp states to result valid; a miss on a full set adds an lru scan of the stamps
// of the ways in use. fetch and unused kinds skip the lookup and row write (idle to resp).
// the back takes no new access until the last (read, compare, write, result) is in the
// result register. reset: rst clears all counters, then a clearing pass over all
// 2**MAX_SET_BITS sets zeroes valid bits and stamps row by row; no request is taken meanwhile
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_top
// set-associative cache model with lru replacement and saturating totals
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_top #(
  parameter int MAX_SET_BITS = slc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = slc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = slc_pkg::ADDR_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [slc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [slc_pkg::CFG_DATA_W-1:0]      cfg_data,
  slc_req_if.sink                            req,
  slc_rsp_if.source                          rsp
);
  localparam int IDX_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ENTRY_W = slc_pkg::OP_W + IDX_W + ADDR_WIDTH;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  logic [slc_pkg::SET_BITS_W-1:0]    set_bits;
  logic [slc_pkg::BLOCK_BITS_W-1:0]  block_bits;
  logic [slc_pkg::WAYS_IN_USE_W-1:0] ways_in_use;

  // queue between front and back
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_in;
  logic [ENTRY_W-1:0] q_out;
  logic               clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      block_bits  <= '0;
      ways_in_use <= slc_pkg::WAYS_IN_USE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        slc_pkg::CFG_SET_BITS:    set_bits    <= cfg_data[slc_pkg::SET_BITS_W-1:0];
        slc_pkg::CFG_BLOCK_BITS:  block_bits  <= cfg_data[slc_pkg::BLOCK_BITS_W-1:0];
        slc_pkg::CFG_WAYS_IN_USE: ways_in_use <= cfg_data[slc_pkg::WAYS_IN_USE_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // front: request transfer, kind decode and tag / set split
  slc_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDR_WIDTH   (ADDR_WIDTH),
    .IDX_W        (IDX_W),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .set_bits   (set_bits),
    .block_bits (block_bits),
    .clearing   (clearing),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  // short queue so that front and back stall independently
  slc_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (slc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: set read, hit / victim choice, row write, totals, result register
  slc_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH),
    .IDX_W        (IDX_W),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .ways_in_use (ways_in_use),
    .q_empty     (q_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .rsp         (rsp)
  );

  // no request transfer during the clearing pass
  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("request taken during clearing pass");

  // a second access only follows a first one
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.second_hit |-> rsp.first_outcome != slc_pkg::OUT_NONE)
    else $error("second hit without a first access");

  // an eviction is always counted
  a_evict_counted: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.first_outcome == slc_pkg::OUT_EVICT |-> rsp.total_evictions != '0)
    else $error("eviction reported with zero total");

  // a miss is always counted
  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.first_outcome == slc_pkg::OUT_MISS |-> rsp.total_misses != '0)
    else $error("miss reported with zero total");
endmodule
`default_nettype wire

### tb/sv/set_assoc_lru_cache_model_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_top_tb
// drives access transfers through several cache geometries, predicts each
// outcome and the running totals with its own lru cache, and checks every
// result transfer field by field, with random sender and receiver stalls over most of the run
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_top_tb;
  import slc_pkg::*;

  localparam int N_SETS  = 1 << MAX_SET_BITS_DEF;
  localparam int N_LINES = N_SETS * MAX_WAYS_DEF;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [63:0]       addr;
  } access_t;

  typedef struct {
    logic [OUTCOME_W-1:0] outcome;
    logic                 second;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
    logic [CNT_W-1:0]     evicts;
  } outcome_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  slc_req_if req_ch ();
  slc_rsp_if rsp_ch ();

  set_assoc_lru_cache_model_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req_ch), .rsp(rsp_ch)
  );

  // pending accesses for the driver, predicted results for the checker
  access_t  pending_accesses[$];
  outcome_t expected_outcomes[$];
  int       n_errors;
  int       n_accepted;
  bit       req_taken;

  // stall percentages, switched by how far the run has got
  int send_idle_pct;
  int recv_idle_pct;

  // shadow configuration
  logic [3:0] cur_set_bits;
  logic [5:0] cur_block_bits;
  logic [3:0] cur_ways;

  // shadow cache
  bit          line_ok[N_LINES];
  logic [63:0] line_tag_q[N_LINES];
  logic [63:0] line_age[N_LINES];
  logic [63:0] use_clock;
  logic [CNT_W-1:0] hits_q, misses_q, evicts_q;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1;
  endfunction

  // one cache lookup and fill, returns the outcome code
  function automatic logic [OUTCOME_W-1:0] lookup_line(input logic [63:0] addr);
    int sb, bb, nw, split, base, victim;
    logic [63:0] tag, idx;
    bit got_free;
    sb = (cur_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cur_set_bits;
    bb = cur_block_bits;
    nw = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : cur_ways);
    split = sb + bb;
    tag = (split >= 64) ? 64'd0 : (addr >> split);
    idx = (addr >> bb) & ((64'd1 << sb) - 1);
    base = int'(idx) * MAX_WAYS_DEF;
    use_clock = use_clock + 1;
    for (int w = 0; w < nw; w++) begin
      if (line_ok[base + w] && line_tag_q[base + w] == tag) begin
        line_age[base + w] = use_clock;
        hits_q = bump(hits_q);
        return OUT_HIT;
      end
    end
    misses_q = bump(misses_q);
    victim = 0;
    got_free = 0;
    for (int w = 0; w < nw; w++) begin
      if (!got_free && !line_ok[base + w]) begin
        victim = w;
        got_free = 1;
      end
    end
    if (!got_free) begin
      // oldest stamp wins, lowest way on a tie
      for (int w = 1; w < nw; w++)
        if (line_age[base + w] < line_age[base + victim]) victim = w;
    end
    line_ok[base + victim] = 1;
    line_tag_q[base + victim] = tag;
    line_age[base + victim] = use_clock;
    if (got_free) return OUT_MISS;
    evicts_q = bump(evicts_q);
    return OUT_EVICT;
  endfunction

  function automatic outcome_t predict_outcome(input access_t a);
    outcome_t r;
    r.outcome = OUT_NONE;
    r.second = 0;
    if (a.kind == KIND_LDST || a.kind == KIND_MODIFY) r.outcome = lookup_line(a.addr);
    if (a.kind == KIND_MODIFY) begin
      void'(lookup_line(a.addr));
      r.second = 1;
    end
    r.hits = hits_q;
    r.misses = misses_q;
    r.evicts = evicts_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // clock and reset
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = CFG_SET_BITS;
    cfg_data = '0;
    req_ch.valid = 0;
    req_ch.kind = KIND_FETCH;
    req_ch.access_address = '0;
    rsp_ch.ready = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 0;
  end

  // driver: new access at the falling edge once the previous one has gone
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 0;
    end else if (!req_ch.valid || req_taken) begin
      req_taken = 0;
      if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        access_t a;
        a = pending_accesses.pop_front();
        req_ch.valid <= 1;
        req_ch.kind <= a.kind;
        req_ch.access_address <= a.addr;
      end else begin
        req_ch.valid <= 0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    rsp_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: predict on each request transfer, check each result transfer
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      access_t a;
      a.kind = req_ch.kind;
      a.addr = req_ch.access_address;
      expected_outcomes.push_back(predict_outcome(a));
      req_taken = 1;
      n_accepted++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        outcome_t e;
        e = expected_outcomes.pop_front();
        if (rsp_ch.first_outcome !== e.outcome)
          report_mismatch("first_outcome", rsp_ch.first_outcome, e.outcome);
        if (rsp_ch.second_hit !== e.second)
          report_mismatch("second_hit", rsp_ch.second_hit, e.second);
        if (rsp_ch.total_hits !== e.hits)
          report_mismatch("total_hits", rsp_ch.total_hits, e.hits);
        if (rsp_ch.total_misses !== e.misses)
          report_mismatch("total_misses", rsp_ch.total_misses, e.misses);
        if (rsp_ch.total_evictions !== e.evicts)
          report_mismatch("total_evictions", rsp_ch.total_evictions, e.evicts);
      end
    end
  end

  // stall pattern: sender light and receiver heavy, then swapped, then none
  always @(posedge clk) begin
    if (n_accepted < 380) begin
      send_idle_pct <= 10;
      recv_idle_pct <= 81;
    end else if (n_accepted < 760) begin
      send_idle_pct <= 81;
      recv_idle_pct <= 10;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [5:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SET_BITS:   cur_set_bits = val[3:0];
      CFG_BLOCK_BITS: cur_block_bits = val;
      default:        cur_ways = val[3:0];
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic wait_idle();
    while (pending_accesses.size() > 0 || req_ch.valid || expected_outcomes.size() > 0)
      @(posedge clk);
    // fetches leave nothing pending but a short pipeline tail
    repeat (20) @(posedge clk);
  endtask

  task automatic push_access(input logic [KIND_W-1:0] k, input logic [63:0] addr);
    access_t a;
    a.kind = k;
    a.addr = addr;
    pending_accesses.push_back(a);
  endtask

  function automatic logic [KIND_W-1:0] random_kind();
    int r;
    r = $urandom_range(99);
    if (r < 10) return KIND_FETCH;
    if (r < 15) return KIND_UNUSED;
    if (r < 65) return KIND_LDST;
    return KIND_MODIFY;
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // random accesses over a small pool of tags and sets, so sets fill and evict
  task automatic random_phase(input int count);
    logic [63:0] tag_pool[6];
    logic [63:0] addr, off_mask;
    int split, bb;
    bb = cur_block_bits;
    split = bb + ((cur_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cur_set_bits);
    off_mask = (bb >= 64) ? '1 : ((64'd1 << bb) - 1);
    foreach (tag_pool[i]) tag_pool[i] = $urandom_range(1) ? random_word() : $urandom_range(15);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 8) begin
        addr = (random_word() & off_mask) | ((64'($urandom_range(3)) << bb) & ~off_mask);
        if (split < 64) addr = addr | (tag_pool[$urandom_range(5)] << split);
      end else begin
        addr = random_word();
      end
      push_access(random_kind(), addr);
    end
  endtask

  initial begin
    n_errors = 0;
    n_accepted = 0;
    req_taken = 0;
    send_idle_pct = 10;
    recv_idle_pct = 81;
    cur_set_bits = 0;
    cur_block_bits = 0;
    cur_ways = 1;
    use_clock = 0;
    hits_q = 0;
    misses_q = 0;
    evicts_q = 0;
    foreach (line_ok[i]) begin
      line_ok[i] = 0;
      line_age[i] = 0;
    end
    @(negedge clk);
    while (rst) @(negedge clk);

    // directed: reset geometry, one set and one way
    push_access(KIND_FETCH, '1);
    push_access(KIND_UNUSED, '1);        // unused kind behaves as a fetch
    push_access(KIND_LDST, '0);          // cold miss
    push_access(KIND_LDST, '0);          // hit
    push_access(KIND_MODIFY, 64'd1);     // eviction, then second access hits
    push_access(KIND_LDST, '1);
    push_access(KIND_MODIFY, '1);
    push_access(KIND_LDST, 64'h8000_0000_0000_0000);
    wait_idle();

    // lru with four ways in one set: fill, touch the oldest, then evict
    write_reg(CFG_WAYS_IN_USE, 6'd4);
    for (int i = 0; i < 4; i++) push_access(KIND_LDST, 64'(i));
    push_access(KIND_LDST, 64'd0);
    push_access(KIND_LDST, 64'd9);       // evicts tag 1, the oldest now
    push_access(KIND_LDST, 64'd1);
    push_access(KIND_LDST, 64'd0);
    wait_idle();

    // wide split gives tag zero; ways and set bits above their limits
    write_reg(CFG_SET_BITS, 6'd15);
    write_reg(CFG_BLOCK_BITS, 6'd63);
    write_reg(CFG_WAYS_IN_USE, 6'd15);
    push_access(KIND_LDST, '1);
    push_access(KIND_LDST, '0);
    push_access(KIND_MODIFY, 64'h7fff_ffff_ffff_ffff);
    push_access(KIND_LDST, 64'h8000_0000_0000_0000);
    random_phase(120);
    wait_idle();

    // random phases over a spread of geometries, the extremes among them
    write_reg(CFG_SET_BITS, 6'd2);
    write_reg(CFG_BLOCK_BITS, 6'd4);
    write_reg(CFG_WAYS_IN_USE, 6'd4);
    random_phase(170);
    wait_idle();

    write_reg(CFG_SET_BITS, 6'd8);
    write_reg(CFG_BLOCK_BITS, 6'd6);
    write_reg(CFG_WAYS_IN_USE, 6'd8);
    random_phase(170);
    wait_idle();

    // no flush on reconfiguration: old lines read with the new split
    write_reg(CFG_WAYS_IN_USE, 6'd0);
    write_reg(CFG_SET_BITS, 6'd1);
    write_reg(CFG_BLOCK_BITS, 6'd0);
    random_phase(150);
    wait_idle();

    write_reg(CFG_SET_BITS, 6'd3);
    write_reg(CFG_BLOCK_BITS, 6'd60);
    write_reg(CFG_WAYS_IN_USE, 6'd2);
    random_phase(150);
    wait_idle();

    write_reg(CFG_SET_BITS, 6'd0);
    write_reg(CFG_BLOCK_BITS, 6'd48);
    write_reg(CFG_WAYS_IN_USE, 6'd8);
    random_phase(150);
    wait_idle();

    write_reg(CFG_SET_BITS, 6'd8);
    write_reg(CFG_BLOCK_BITS, 6'd2);
    write_reg(CFG_WAYS_IN_USE, 6'd3);
    random_phase(180);
    wait_idle();

    if (n_errors == 0) begin
      $display("set_assoc_lru_cache_model_top verification clean");
    end else begin
      $display("set_assoc_lru_cache_model_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("set_assoc_lru_cache_model_top verification failed");
    $finish;
  end

endmodule
